/* hdl/tfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_pkg: shared types and constants of the texel format packer
// output format codes, the widths of the item fields and of the byte buffer
// ----------------------------------------------------------------------------
package tfp_pkg;

	localparam int unsigned ChanW   = 8;
	localparam int unsigned NibW    = 4;
	localparam int unsigned FmtW    = 4;
	localparam int unsigned MaxBytes = 4;
	localparam int unsigned IdxW    = 2;
	localparam int unsigned CntW    = 3;

	typedef enum logic [FmtW-1:0] {
		FMT_RGBA32 = 4'd0,
		FMT_RGBA16 = 4'd1,
		FMT_I4     = 4'd2,
		FMT_I8     = 4'd3,
		FMT_IA4    = 4'd4,
		FMT_IA8    = 4'd5,
		FMT_IA16   = 4'd6,
		FMT_CI4    = 4'd7,
		FMT_CI8    = 4'd8
	} fmt_t;

	typedef logic [ChanW-1:0] chan_t;
	typedef logic [NibW-1:0]  nib_t;

endpackage

/* hdl/texel_format_packer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_format_packer_core: pixel stream to packed texture bytes
// one pixel item in, zero to four texture byte items out, in the configured
// format; nibble formats pair two pixels into one byte
// ----------------------------------------------------------------------------
// One pixel item is taken into an input register, packed combinationally into
// a four-byte result buffer, and the buffer is sent out on the texture channel
// one byte item per cycle while tex_stall is low. The one-byte output port sets
// the rate: a pixel gives 4 bytes in rgba32, 2 in rgba16 and ia16, 1 in i8,
// ia8 and ci8, and in i4, ia4 and ci4 the first pixel of a pair gives no byte
// and the second gives one. With tex_stall low, a new pixel is taken while the
// last byte of the previous one is being taken, so the one-byte formats run at
// one pixel per cycle. The format register is written on the cfg channel
// (always ready) and must only change while the block is idle; codes 9 to 15
// give no bytes. After a pixel marked last_of_image the nibble pairing starts
// over, and an odd final pixel in a nibble format is sent with a zero low half.
module texel_format_packer_core
	import tfp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// format register write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [FmtW-1:0]     cfg_data,
	// pixel items
	input  logic                pix_valid,
	output logic                pix_stall,
	input  logic [ChanW-1:0]    red,
	input  logic [ChanW-1:0]    green,
	input  logic [ChanW-1:0]    blue,
	input  logic [ChanW-1:0]    alpha,
	input  logic [ChanW-1:0]    palette_index,
	input  logic                last_of_image,
	// texture byte items
	output logic                tex_valid,
	input  logic                tex_stall,
	output logic [ChanW-1:0]    out_byte,
	output logic                last_of_pixel
);

	// format register
	logic [FmtW-1:0] fmt_q;

	// input register stage
	logic            valid_s1;
	chan_t           red_s1;
	chan_t           green_s1;
	chan_t           blue_s1;
	chan_t           alpha_s1;
	chan_t           pidx_s1;
	logic            last_img_s1;

	// result buffer stage
	chan_t           buf_s2 [MaxBytes];
	logic [CntW-1:0] cnt_s2;
	logic [IdxW-1:0] idx_s2;

	// nibble pairing state
	logic            phase_q;
	nib_t            held_q;

	// packer outputs
	chan_t           pk_bytes [MaxBytes];
	logic [CntW-1:0] pk_cnt;
	logic            pk_phase;
	nib_t            pk_held;
	logic            pk_nib_fmt;
	nib_t            pk_nib;
	logic            abit;

	logic            pix_take;
	logic            tex_take;
	logic            buf_last;
	logic            buf_free;
	logic            s1_adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGBA32;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// handshakes
	// ------------------------------------------------------------------
	assign tex_valid     = (cnt_s2 != '0);
	assign out_byte      = buf_s2[idx_s2];
	assign buf_last      = ({1'b0, idx_s2} == (cnt_s2 - CntW'(1)));
	assign last_of_pixel = buf_last;
	assign tex_take      = tex_valid && !tex_stall;

	// buffer can take a packed pixel when empty or when its last byte leaves now
	assign buf_free  = !tex_valid || (tex_take && buf_last);
	assign s1_adv    = valid_s1 && buf_free;
	assign pix_stall = valid_s1 && !buf_free;
	assign pix_take  = pix_valid && !pix_stall;

	// ------------------------------------------------------------------
	// input register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_take) begin
			red_s1      <= red;
			green_s1    <= green;
			blue_s1     <= blue;
			alpha_s1    <= alpha;
			pidx_s1     <= palette_index;
			last_img_s1 <= last_of_image;
		end
	end

	// ------------------------------------------------------------------
	// packer: bytes for the registered pixel, most significant first
	// ------------------------------------------------------------------
	assign abit = (alpha_s1 != '0);

	always_comb begin
		for (int k = 0; k < MaxBytes; k++) begin
			pk_bytes[k] = '0;
		end
		pk_cnt     = '0;
		pk_nib_fmt = 1'b0;
		pk_nib     = '0;
		pk_phase   = phase_q;
		pk_held    = held_q;

		case (fmt_q)
			FMT_RGBA32: begin
				pk_bytes[0] = red_s1;
				pk_bytes[1] = green_s1;
				pk_bytes[2] = blue_s1;
				pk_bytes[3] = alpha_s1;
				pk_cnt      = CntW'(4);
			end
			FMT_RGBA16: begin
				// 5551 word, high byte first
				pk_bytes[0] = {red_s1[7:3], green_s1[7:5]};
				pk_bytes[1] = {green_s1[4:3], blue_s1[7:3], abit};
				pk_cnt      = CntW'(2);
			end
			FMT_I4: begin
				pk_nib_fmt = 1'b1;
				pk_nib     = red_s1[7:4];
			end
			FMT_I8: begin
				pk_bytes[0] = red_s1;
				pk_cnt      = CntW'(1);
			end
			FMT_IA4: begin
				pk_nib_fmt = 1'b1;
				pk_nib     = {red_s1[7:5], abit};
			end
			FMT_IA8: begin
				pk_bytes[0] = {red_s1[7:4], alpha_s1[7:4]};
				pk_cnt      = CntW'(1);
			end
			FMT_IA16: begin
				pk_bytes[0] = red_s1;
				pk_bytes[1] = alpha_s1;
				pk_cnt      = CntW'(2);
			end
			FMT_CI4: begin
				pk_nib_fmt = 1'b1;
				pk_nib     = pidx_s1[3:0];
			end
			FMT_CI8: begin
				pk_bytes[0] = pidx_s1;
				pk_cnt      = CntW'(1);
			end
			default: begin
				pk_cnt = '0;
			end
		endcase

		if (pk_nib_fmt) begin
			if (phase_q) begin
				// second of pair: held nibble high, this one low
				pk_bytes[0] = {held_q, pk_nib};
				pk_cnt      = CntW'(1);
				pk_phase    = 1'b0;
				pk_held     = '0;
			end else if (last_img_s1) begin
				// odd pixel at end of image, low half zero
				pk_bytes[0] = {pk_nib, nib_t'(0)};
				pk_cnt      = CntW'(1);
			end else begin
				pk_held  = pk_nib;
				pk_phase = 1'b1;
			end
		end

		// pairing starts over after the end of an image
		if (last_img_s1) begin
			pk_phase = 1'b0;
			pk_held  = '0;
		end
	end

	// ------------------------------------------------------------------
	// pairing state, committed as the pixel moves into the buffer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			held_q  <= '0;
		end else if (s1_adv) begin
			phase_q <= pk_phase;
			held_q  <= pk_held;
		end
	end

	// ------------------------------------------------------------------
	// result buffer and byte serializer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
			idx_s2 <= '0;
		end else if (s1_adv) begin
			cnt_s2 <= pk_cnt;
			idx_s2 <= '0;
		end else if (tex_take) begin
			if (buf_last) begin
				cnt_s2 <= '0;
				idx_s2 <= '0;
			end else begin
				idx_s2 <= idx_s2 + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int k = 0; k < MaxBytes; k++) begin
				buf_s2[k] <= pk_bytes[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// a held nibble only exists while waiting for the second pixel of a pair
	a_held_needs_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!phase_q |-> (held_q == '0))
		else $error("held nibble nonzero outside a pair");

	// never more bytes buffered than one pixel can produce
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s2 <= CntW'(MaxBytes))
		else $error("byte count out of range");

	// the read pointer stays inside the buffered bytes
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tex_valid |-> ({1'b0, idx_s2} < cnt_s2))
		else $error("byte index past byte count");

	// a pixel is only stalled while one is already registered
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> valid_s1)
		else $error("pixel stalled with empty input register");

	// last byte taken with nothing to follow empties the buffer
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(tex_take && last_of_pixel && !valid_s1) |=> !tex_valid)
		else $error("buffer still valid after final byte");

endmodule
